[sv/crc16_swapped_pair_stream_macros.svh]
// ----------------------------------------------------------------------------
// CRC-16 swapped pair stream: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CRC16_SWAPPED_PAIR_STREAM_MACROS_SVH
`define CRC16_SWAPPED_PAIR_STREAM_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on the rising clock, off while reset is asserted.
`define CRC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on the rising clock, also during reset.
`define CRC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRC_ASSERT(label, clk, rst_n, prop, msg)
`define CRC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/crc16cms_pkg.sv]
// ----------------------------------------------------------------------------
// CRC-16 swapped pair stream: package
// Shared types, constants and the byte fold of the CRC-16 (poly 0x8005).
// ----------------------------------------------------------------------------
`default_nettype none

package crc16cms_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // One accepted input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result handed from the core to the output register.
  typedef struct packed {
    logic        valid;
    logic [15:0] crc_value;
  } crc_res_t;

  // Fold one byte into the CRC, MSB first, not reflected.
  function automatic logic [15:0] fold_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/crc16cms_in_reg.sv]
// ----------------------------------------------------------------------------
// CRC-16 swapped pair stream: input register
// Captures one input beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16cms_in_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire crc16cms_pkg::in_item_t item_i,
  output logic                       valid_o,
  output crc16cms_pkg::in_item_t     item_o,
  input  wire logic                  take_i
);

  logic                   valid_q, valid_d;
  crc16cms_pkg::in_item_t item_q;

  // Free when empty or when the held beat leaves this cycle.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[sv/crc16cms_core.sv]
// ----------------------------------------------------------------------------
// CRC-16 swapped pair stream: CRC core
// Holds the running CRC and the even-position byte; folds pairs swapped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_swapped_pair_stream_macros.svh"

module crc16cms_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input  wire crc16cms_pkg::in_item_t item_i,
  input  wire logic                   out_space_i,
  output logic                        take_o,
  output crc16cms_pkg::crc_res_t      res_o
);

  logic [15:0] crc_q, crc_d;
  logic        byte_held_q, byte_held_d;
  logic [7:0]  held_byte_q;
  logic [15:0] crc_next;

  // A beat that ends a message needs room for its result.
  assign take_o = valid_i && (!item_i.last_byte || out_space_i);

  always_comb begin
    if (byte_held_q) begin
      crc_next = crc16cms_pkg::fold_byte(
                   crc16cms_pkg::fold_byte(crc_q, item_i.data_byte), held_byte_q);
    end else if (item_i.last_byte) begin
      crc_next = crc16cms_pkg::fold_byte(crc_q, item_i.data_byte);
    end else begin
      crc_next = crc_q;
    end
  end

  always_comb begin
    crc_d       = crc_q;
    byte_held_d = byte_held_q;
    if (take_o) begin
      if (item_i.last_byte) begin
        crc_d       = crc16cms_pkg::CRC_INIT;
        byte_held_d = 1'b0;
      end else begin
        crc_d       = crc_next;
        byte_held_d = !byte_held_q;
      end
    end
  end

  assign res_o.valid     = take_o && item_i.last_byte;
  assign res_o.crc_value = crc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= crc16cms_pkg::CRC_INIT;
      byte_held_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      byte_held_q <= byte_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && !byte_held_q && !item_i.last_byte) begin
      held_byte_q <= item_i.data_byte;
    end
  end

  `CRC_ASSERT(a_end_clears_hold, clk_i, rst_ni, (take_o && item_i.last_byte) |=> !byte_held_q, "pending byte survived end of message")
  `CRC_ASSERT(a_end_restarts_crc, clk_i, rst_ni, (take_o && item_i.last_byte) |=> (crc_q == crc16cms_pkg::CRC_INIT), "CRC not restarted after message")
  `CRC_ASSERT(a_even_byte_held, clk_i, rst_ni, (take_o && !item_i.last_byte && !byte_held_q) |=> byte_held_q, "even byte not held")
  `CRC_ASSERT(a_idle_stable, clk_i, rst_ni, !take_o |=> ($stable(crc_q) && $stable(byte_held_q)), "CRC state moved without a beat")

endmodule

`default_nettype wire

[sv/crc16cms_out_reg.sv]
// ----------------------------------------------------------------------------
// CRC-16 swapped pair stream: output register
// Holds a finished CRC until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16cms_out_reg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire crc16cms_pkg::crc_res_t res_i,
  output logic                        space_o,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output logic [15:0]                 crc_value_o
);

  logic        valid_q, valid_d;
  logic [15:0] crc_q;

  // Room when empty or when the held result leaves this cycle.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_i.valid) begin
      crc_q <= res_i.crc_value;
    end
  end

  assign valid_o     = valid_q;
  assign crc_value_o = crc_q;

endmodule

`default_nettype wire

[sv/crc16_swapped_pair_stream.sv]
// ----------------------------------------------------------------------------
// CRC-16 swapped pair stream
// Byte-stream CRC-16 (poly 0x8005, init 0xFFFF, no reflection, no final XOR).
// ----------------------------------------------------------------------------
// Feed a message one byte per beat on the slave side, with tlast on its final
// byte; in the cycle after the core takes that byte, the finished CRC appears
// on the master side as a single beat. Bytes are folded in swapped pairs: the
// byte at an even position waits until its odd partner arrives, the partner is
// folded first and the held byte second. A lone trailing byte of an odd-length
// message is folded by itself. After each message the CRC restarts at 0xFFFF.
// Rate: one beat per clock while no last byte waits for output room; each beat
// is held in the input register, the core folds up to two bytes as it takes a
// beat, and the result sits in the output register from the next cycle. A result
// held by a stalled master side only blocks a later last byte, never the bytes
// in between.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_swapped_pair_stream (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side: message bytes.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  // Master side: finished CRC.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [15:0] crc_value
);

  crc16cms_pkg::in_item_t in_item;
  crc16cms_pkg::in_item_t reg_item;
  crc16cms_pkg::crc_res_t core_res;
  logic                   reg_valid;
  logic                   core_take;
  logic                   out_space;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.last_byte = s_axis_tlast_i;

  // Hold the incoming beat until the core takes it.
  crc16cms_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .item_o  (reg_item),
    .take_i  (core_take)
  );

  // Advance the CRC; a last byte waits only for room in the output register.
  crc16cms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (reg_valid),
    .item_i      (reg_item),
    .out_space_i (out_space),
    .take_o      (core_take),
    .res_o       (core_res)
  );

  // Hold the finished CRC for the master side.
  crc16cms_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (core_res),
    .space_o     (out_space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .crc_value_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
